// ===== rtl/oal_pkg.sv =====
`timescale 1ns / 1ps
// oal_pkg: shared widths, operation and status codes and structs for the
// ordered array list. Depends on nothing; every other file uses it.
package oal_pkg;

   // item field widths
   localparam int MODE_W   = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 4;
   localparam int LEN_W    = 5;

   // default list depth
   localparam int DEPTH_DEFAULT = 16;

   // match flags examined per scan cycle
   localparam int CHUNK   = 16;
   localparam int CHUNK_W = 4;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADPOS   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

   // per-cycle command to every cell
   typedef struct packed {
      logic insert_ok;
      logic search;
   } cell_ctrl_type;

   // scanner result
   typedef struct packed {
      logic               done;
      logic               hit;
      logic [FOUND_W-1:0] found_index;
   } scan_res_type;

   // result item payload
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FOUND_W-1:0]  found_index;
      logic [LEN_W-1:0]    length;
   } rsp_type;

endpackage

// ===== rtl/oal_req_if.sv =====
`timescale 1ns / 1ps
// oal_req_if: request channel (valid/ready plus operation fields).
// Depends on oal_pkg for field widths.
interface oal_req_if;
   logic                                valid;
   logic                                ready;
   logic [oal_pkg::MODE_W-1:0]          mode;
   logic [oal_pkg::POS_W-1:0]           position;
   logic signed [oal_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

// ===== rtl/oal_rsp_if.sv =====
`timescale 1ns / 1ps
// oal_rsp_if: response channel (valid/ready plus result fields).
// Depends on oal_pkg for field widths.
interface oal_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [oal_pkg::STATUS_W-1:0] status;
   logic [oal_pkg::FOUND_W-1:0]  found_index;
   logic [oal_pkg::LEN_W-1:0]    length;

   modport source (output valid, output status, output found_index, output length, input ready);
   modport sink   (input valid, input status, input found_index, input length, output ready);
endinterface

// ===== rtl/ordered_array_list.sv =====
`timescale 1ns / 1ps
// ordered_array_list: clear and insert results are registered at the accepting edge
// when the output register is free, else held as pending; search first registers a
// compare in the cells, then the scanner walks 16 match flags per cycle. One item is in
// work at a time; a new item is taken while the previous result waits on rsp.
// Reset (synchronous) empties the list and clears control; entry storage is not cleared.
module ordered_array_list #(
   parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   oal_req_if.sink          req_chan,
   oal_rsp_if.source        rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = oal_pkg::POS_W;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int LEN_W = oal_pkg::LEN_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   oal_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   oal_pkg::rsp_type              pend_ff, pend_in;

   logic                          accept;
   logic                          out_free;
   logic                          full;
   logic                          bad_pos;
   oal_pkg::cell_ctrl_type        ctrl;
   oal_pkg::rsp_type              imm_res;
   oal_pkg::rsp_type              srch_res;
   oal_pkg::scan_res_type         scan_res;
   logic                          load_out;
   oal_pkg::rsp_type              out_res;
   logic [CNT_W-1:0]              pos_cell;

   logic signed [oal_pkg::VALUE_W-1:0] entry_w [DEPTH];
   logic [DEPTH-1:0]                   hit_w;

   // handshake
   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   // insert checks
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign bad_pos  = (CMP_W'(req_chan.position) > CMP_W'(count_ff));
   assign pos_cell = CNT_W'(req_chan.position);

   // immediate result and count update for clear, insert and unused mode
   always_comb begin
      imm_res.status      = oal_pkg::STAT_OK;
      imm_res.found_index = '0;
      imm_res.length      = LEN_W'(count_ff);
      ctrl.insert_ok      = 1'b0;
      ctrl.search         = 1'b0;
      count_in            = count_ff;
      case (req_chan.mode)
         oal_pkg::MODE_CLEAR: begin
            imm_res.length = '0;
            if (accept) begin
               count_in = '0;
            end
         end
         oal_pkg::MODE_INSERT: begin
            if (full) begin
               imm_res.status = oal_pkg::STAT_FULL;
            end else if (bad_pos) begin
               imm_res.status = oal_pkg::STAT_BADPOS;
            end else begin
               imm_res.length = LEN_W'(count_ff + 1'b1);
               ctrl.insert_ok = accept;
               if (accept) begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         oal_pkg::MODE_SEARCH: begin
            ctrl.search = accept;
         end
         default: begin
         end
      endcase
   end

   // cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [oal_pkg::VALUE_W-1:0] left;
      if (g == 0) begin : g_head
         assign left = req_chan.value;
      end else begin : g_body
         assign left = entry_w[g-1];
      end
      oal_cell #(
         .INDEX (g),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .position   (pos_cell),
         .count      (count_ff),
         .value      (req_chan.value),
         .left_entry (left),
         .entry      (entry_w[g]),
         .hit        (hit_w[g])
      );
   end

   // first-match scanner
   oal_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .start (ctrl.search),
      .run   (state_ff == ST_SCAN),
      .hits  (hit_w),
      .res   (scan_res)
   );

   always_comb begin
      srch_res.status      = scan_res.hit ? oal_pkg::STAT_OK : oal_pkg::STAT_NOTFOUND;
      srch_res.found_index = scan_res.hit ? scan_res.found_index : '0;
      srch_res.length      = LEN_W'(count_ff);
   end

   // sequencing and output register loading
   always_comb begin
      state_in = state_ff;
      load_out = 1'b0;
      out_res  = imm_res;
      pend_in  = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.mode == oal_pkg::MODE_SEARCH) begin
                  state_in = ST_SCAN;
               end else if (out_free) begin
                  load_out = 1'b1;
               end else begin
                  pend_in  = imm_res;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_SCAN: begin
            out_res = srch_res;
            if (scan_res.done) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  pend_in  = srch_res;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            out_res = pend_ff;
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = out_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.found_index = rsp_data_ff.found_index;
   assign rsp_chan.length      = rsp_data_ff.length;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list length beyond depth");

   a_hold_needs_busy_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |-> rsp_valid_ff)
      else $error("pending result while output register is empty");

   a_full_insert_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.mode == oal_pkg::MODE_INSERT) && full) |=> $stable(count_ff))
      else $error("insert into full list changed length");

   a_scan_only_after_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SCAN) && (state_in == ST_SCAN) |-> ctrl.search)
      else $error("scan started without a search item");

endmodule

// ===== rtl/oal_cell.sv =====
`timescale 1ns / 1ps
// oal_cell: one list slot; takes its left neighbor's entry on insert and
// flags a match on search. Depends on oal_pkg.
module oal_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                               clock,
   input  oal_pkg::cell_ctrl_type             ctrl,
   input  logic [CNT_W-1:0]                   position,
   input  logic [CNT_W-1:0]                   count,
   input  logic signed [oal_pkg::VALUE_W-1:0] value,
   input  logic signed [oal_pkg::VALUE_W-1:0] left_entry,
   output logic signed [oal_pkg::VALUE_W-1:0] entry,
   output logic                               hit
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic signed [oal_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                               hit_ff, hit_in;

   // insert: own slot takes the new value, later live slots shift back
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert_ok) begin
         if (MY_INDEX == position) begin
            entry_in = value;
         end else if ((MY_INDEX > position) && (MY_INDEX <= count)) begin
            entry_in = left_entry;
         end
      end
   end

   // search: match only on live slots
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.search) begin
         hit_in = (entry_ff == value) && (MY_INDEX < count);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= hit_in;
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== rtl/oal_scan.sv =====
`timescale 1ns / 1ps
// oal_scan: walks the cells' match flags one chunk per cycle, lowest first,
// and reports the first match. Depends on oal_pkg.
module oal_scan #(
   parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  run,
   input  logic [DEPTH-1:0]      hits,
   output oal_pkg::scan_res_type res
);

   localparam int CH     = oal_pkg::CHUNK;
   localparam int CW     = oal_pkg::CHUNK_W;
   localparam int FW     = oal_pkg::FOUND_W;
   localparam int NCHUNK = (DEPTH + CH - 1) / CH;
   localparam int PAD_W  = NCHUNK * CH;
   localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int SCAN_W = $clog2(PAD_W);

   logic [CHK_W-1:0]  chunk_ff, chunk_in;
   logic [PAD_W-1:0]  hits_pad;
   logic [SCAN_W-1:0] base;
   logic [CH-1:0]     chunk_bits;
   logic [CW-1:0]     enc;
   logic              any;
   logic              last;
   logic              done;
   logic [SCAN_W-1:0] index;

   // select the current chunk of flags
   assign hits_pad   = PAD_W'(hits);
   assign base       = SCAN_W'(chunk_ff) << CW;
   assign chunk_bits = hits_pad[base +: CH];
   assign any        = |chunk_bits;
   assign last       = (chunk_ff == CHK_W'(NCHUNK - 1));

   // lowest set flag in the chunk
   always_comb begin
      enc = '0;
      for (int j = CH - 1; j >= 0; j--) begin
         if (chunk_bits[j]) begin
            enc = CW'(j);
         end
      end
   end

   assign index = base | SCAN_W'(enc);
   assign done  = run && (any || last);

   // chunk counter
   always_comb begin
      chunk_in = chunk_ff;
      if (start) begin
         chunk_in = '0;
      end else if (run && !done) begin
         chunk_in = chunk_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= '0;
      end else begin
         chunk_ff <= chunk_in;
      end
   end

   assign res.done        = done;
   assign res.hit         = any;
   assign res.found_index = FW'(index);

endmodule
